// ===== sv/key_value_text_parser_assert.svh =====
// Assertion macros for the key/value text parser.
`ifndef KEY_VALUE_TEXT_PARSER_ASSERT_SVH
`define KEY_VALUE_TEXT_PARSER_ASSERT_SVH

// Property must hold on every clock edge out of reset.
`define KVTP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post must hold on the next clock edge.
`define KVTP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/kvtp_pkg.sv =====
// Shared constants and types for the key/value text parser.
package kvtp_pkg;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CTRL_WS_LO   = 8'h09;
    localparam logic [7:0] CTRL_WS_HI   = 8'h0D;

    localparam int TDATA_W = 64;

    typedef struct packed {
        logic        token_done;
        logic        token_is_key;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [7:0]  pair_count;
        logic        parse_error;
        logic        message_done;
        logic        message_ok;
    } result_t;

endpackage

// ===== sv/key_value_text_parser.sv =====
// Key/value text parser: one byte in, one result out, per transaction.
// Each input byte passes through the input register and then the result register on its way to the result.
// Throughput: one byte per cycle; ready falls only when the result register is held.
// Reset: rst_n clears valid flags and parser state; state also returns to its
// reset values after the byte marked tlast.
`include "key_value_text_parser_assert.svh"

module key_value_text_parser
    import kvtp_pkg::*;
#(
    parameter int MAX_MESSAGE_LEN = 65536,
    parameter int MAX_PAIRS       = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,   // last_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] token_done, [16:1] token_start, [32:17] token_length,
    // [48:33] line_number, [56:49] pair_count, [57] parse_error,
    // [58] message_ok, [63:59] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // token_is_key
    output logic               m_axis_tlast    // message_done
);

    localparam int POS_CAP_INT  = (MAX_MESSAGE_LEN - 1 > 65535) ? 65535 : MAX_MESSAGE_LEN - 1;
    localparam int PAIR_CAP_INT = (MAX_PAIRS > 255) ? 255 : MAX_PAIRS;
    localparam logic [15:0] POS_CAP  = 16'(POS_CAP_INT);
    localparam logic [7:0]  PAIR_CAP = 8'(PAIR_CAP_INT);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    logic        expect_key_reg, expect_key_next;
    logic [15:0] raw_len_reg, raw_len_next;
    logic [15:0] trim_len_reg, trim_len_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] line_reg, line_next;
    logic [7:0]  pair_reg, pair_next;
    logic        err_reg, err_next;

    // result register
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;

    logic out_free;
    logic advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_comb
    begin
        logic ws;
        logic finish;
        logic [15:0] raw_inc;

        ws      = (in_byte_reg inside {[CTRL_WS_LO:CTRL_WS_HI], CHAR_SPACE});
        finish  = 1'b0;
        raw_inc = 16'd0;

        expect_key_next = expect_key_reg;
        raw_len_next    = raw_len_reg;
        trim_len_next   = trim_len_reg;
        start_next      = start_reg;
        pos_next        = pos_reg;
        line_next       = line_reg;
        pair_next       = pair_reg;
        err_next        = err_reg;

        res              = '0;
        res.message_done = in_last_reg;

        if (!err_reg)
        begin
            if (in_byte_reg == CHAR_NEWLINE && line_reg != 16'hFFFF)
            begin
                line_next = line_reg + 16'd1;
            end

            if (ws && raw_len_reg == 16'd0)
            begin
                // leading whitespace, blank lines included
            end
            else if (in_byte_reg == CHAR_COLON)
            begin
                if (!expect_key_reg || raw_len_reg == 16'd0)
                    err_next = 1'b1;
                else
                    finish = 1'b1;
            end
            else if (in_byte_reg == CHAR_NEWLINE)
            begin
                if (expect_key_reg)
                    err_next = 1'b1;
                else
                    finish = 1'b1;
            end
            else
            begin
                if (raw_len_reg == 16'd0)
                    start_next = pos_reg;
                raw_inc = (raw_len_reg != 16'hFFFF) ? raw_len_reg + 16'd1 : raw_len_reg;
                raw_len_next = raw_inc;
                if (!ws)
                    trim_len_next = raw_inc;
                if (in_last_reg)
                    finish = 1'b1;
            end

            if (finish)
            begin
                res.token_done   = 1'b1;
                res.token_is_key = expect_key_reg;
                res.token_start  = start_next;
                res.token_length = trim_len_next;
                if (!expect_key_reg && pair_reg < PAIR_CAP)
                    pair_next = pair_reg + 8'd1;
                expect_key_next = !expect_key_reg;
                raw_len_next    = 16'd0;
                trim_len_next   = 16'd0;
            end

            if (pos_reg < POS_CAP)
                pos_next = pos_reg + 16'd1;
        end

        res.line_number = line_next;
        res.pair_count  = pair_next;
        res.parse_error = err_next;
        res.message_ok  = in_last_reg && !err_next && expect_key_next
                          && raw_len_next == 16'd0 && pair_next != 8'd0;

        if (in_last_reg)
        begin
            expect_key_next = 1'b1;
            raw_len_next    = 16'd0;
            trim_len_next   = 16'd0;
            start_next      = 16'd0;
            pos_next        = 16'd0;
            line_next       = 16'd0;
            pair_next       = 8'd0;
            err_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_key_reg <= 1'b1;
            raw_len_reg    <= '0;
            trim_len_reg   <= '0;
            start_reg      <= '0;
            pos_reg        <= '0;
            line_reg       <= '0;
            pair_reg       <= '0;
            err_reg        <= 1'b0;
        end
        else if (advance)
        begin
            expect_key_reg <= expect_key_next;
            raw_len_reg    <= raw_len_next;
            trim_len_reg   <= trim_len_next;
            start_reg      <= start_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            pair_reg       <= pair_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.token_is_key;
    assign m_axis_tlast  = out_reg.message_done;
    assign m_axis_tdata  = {5'd0,
                            out_reg.message_ok,
                            out_reg.parse_error,
                            out_reg.pair_count,
                            out_reg.line_number,
                            out_reg.token_length,
                            out_reg.token_start,
                            out_reg.token_done};

    `KVTP_ASSERT_NEXT(a_reset_after_last, advance && in_last_reg,
        expect_key_reg && pair_reg == 8'd0 && line_reg == 16'd0 && !err_reg
        && raw_len_reg == 16'd0 && pos_reg == 16'd0,
        "parser state not cleared after last byte")

    `KVTP_ASSERT_NEXT(a_error_sticky, err_reg && !(advance && in_last_reg), err_reg,
        "error flag dropped inside a message")

    `KVTP_ASSERT(a_ok_needs_clean_end,
        !(m_axis_tvalid && out_reg.message_ok)
        || (out_reg.message_done && !out_reg.parse_error && out_reg.pair_count != 8'd0),
        "message_ok without a clean end of message")

    `KVTP_ASSERT(a_key_implies_done,
        !(m_axis_tvalid && out_reg.token_is_key) || out_reg.token_done,
        "token_is_key set without a finished token")

    `KVTP_ASSERT(a_trim_within_raw,
        trim_len_reg <= raw_len_reg && pair_reg <= PAIR_CAP,
        "trimmed length or pair count out of range")

endmodule

// ===== sim/tb_key_value_text_parser.sv =====
// Self-checking testbench for key_value_text_parser: directed, random and saturating messages.
`timescale 1ns / 100ps

module tb_key_value_text_parser
    import kvtp_pkg::*;
();

    localparam logic [7:0]  PAIR_LIMIT = 8'd255;     // min(MAX_PAIRS, 255)
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          RANDOM_ITEMS = 850;
    localparam int          CALM_ITEMS   = 250;       // tail of the random part, no idling
    localparam int          PAIR_RUN     = 258;       // enough pairs to pass the pair limit

    // Tracks parser state and checks each result transaction against the prediction.
    class kv_token_scoreboard;
        result_t     expected_results[$];
        logic        want_key;
        logic [15:0] raw_len;
        logic [15:0] trim_len;
        logic [15:0] tok_start;
        logic [15:0] byte_pos;
        logic [15:0] lines;
        logic [7:0]  pairs;
        logic        err;
        int          n_bytes;
        int          n_msgs;
        int          n_ok_msgs;
        int          n_err_msgs;
        int          n_tokens;
        int          n_checked;
        int          n_fail;

        function new();
            clear_message();
            n_bytes = 0;
            n_msgs = 0;
            n_ok_msgs = 0;
            n_err_msgs = 0;
            n_tokens = 0;
            n_checked = 0;
            n_fail = 0;
        endfunction

        function void clear_message();
            want_key = 1'b1;
            raw_len = '0;
            trim_len = '0;
            tok_start = '0;
            byte_pos = '0;
            lines = '0;
            pairs = '0;
            err = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == CHAR_SPACE || (b >= CTRL_WS_LO && b <= CTRL_WS_HI);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            result_t     r;
            logic        fin;
            logic [15:0] pos;
            r = '0;
            fin = 1'b0;
            n_bytes++;
            if (!err) begin
                pos = byte_pos;
                // newline is counted even if it turns out to be an error
                if (b == CHAR_NEWLINE && lines != COUNT_MAX)
                    lines++;
                if (is_blank(b) && raw_len == 0) begin
                    // skip leading whitespace, blank lines included
                end else if (b == CHAR_COLON) begin
                    if (!want_key || raw_len == 0)
                        err = 1'b1;
                    else
                        fin = 1'b1;
                end else if (b == CHAR_NEWLINE) begin
                    if (want_key)
                        err = 1'b1;
                    else
                        fin = 1'b1;
                end else begin
                    if (raw_len == 0)
                        tok_start = pos;
                    if (raw_len != COUNT_MAX)
                        raw_len++;
                    if (!is_blank(b))
                        trim_len = raw_len;
                    if (lst)
                        fin = 1'b1;
                end
                if (fin) begin
                    r.token_done = 1'b1;
                    r.token_is_key = want_key;
                    r.token_start = tok_start;
                    r.token_length = trim_len;
                    if (!want_key && pairs != PAIR_LIMIT)
                        pairs++;
                    want_key = !want_key;
                    raw_len = '0;
                    trim_len = '0;
                end
                if (byte_pos != COUNT_MAX)
                    byte_pos++;
            end
            r.line_number = lines;
            r.pair_count = pairs;
            r.parse_error = err;
            r.message_done = lst;
            if (lst)
                r.message_ok = !err && want_key && raw_len == 0 && pairs != 0;
            expected_results.push_back(r);
            if (lst) begin
                n_msgs++;
                if (r.message_ok)
                    n_ok_msgs++;
                if (err)
                    n_err_msgs++;
                clear_message();
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_results.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result transaction #%0d, nothing pending", n_checked);
                n_checked++;
                return;
            end
            exp = expected_results.pop_front();
            if (got !== exp) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("mismatch at result #%0d", n_checked);
                    $display("  exp: done=%0b key=%0b start=%0d len=%0d line=%0d pairs=%0d err=%0b last=%0b ok=%0b",
                             exp.token_done, exp.token_is_key, exp.token_start, exp.token_length,
                             exp.line_number, exp.pair_count, exp.parse_error, exp.message_done,
                             exp.message_ok);
                    $display("  got: done=%0b key=%0b start=%0d len=%0d line=%0d pairs=%0d err=%0b last=%0b ok=%0b",
                             got.token_done, got.token_is_key, got.token_start, got.token_length,
                             got.line_number, got.pair_count, got.parse_error, got.message_done,
                             got.message_ok);
                end
            end else if (exp.token_done) begin
                n_tokens++;
            end
            n_checked++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    kv_token_scoreboard sb;
    logic [7:0]         msg[$];
    bit                 idle_on;
    int                 quiet_cycles;

    key_value_text_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // One input transaction; optional idle burst before it.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_byte(b, lst);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_text(input string s);
        msg.delete();
        for (int i = 0; i < s.len(); i++)
            msg.push_back(s[i]);
        send_message();
    endtask

    function automatic logic [7:0] rand_blank(bit allow_newline);
        logic [7:0] b;
        do
            b = ($urandom_range(0, 1) == 0) ? CHAR_SPACE
                                            : 8'($urandom_range(CTRL_WS_LO, CTRL_WS_HI));
        while (!allow_newline && b == CHAR_NEWLINE);
        return b;
    endfunction

    function automatic logic [7:0] rand_text_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_COLON || b == CHAR_NEWLINE);
        return b;
    endfunction

    task automatic add_blanks(input bit allow_newline);
        repeat ($urandom_range(0, 2)) msg.push_back(rand_blank(allow_newline));
    endtask

    task automatic add_token();
        repeat ($urandom_range(1, 6)) msg.push_back(rand_text_char());
    endtask

    // Mostly well-formed messages with random content; some noise and broken ones.
    task automatic build_random_message();
        int kind;
        int npairs;
        int idx;
        msg.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom_range(0, 255)));
            return;
        end
        npairs = $urandom_range(1, 5);
        for (int p = 0; p < npairs; p++)
        begin
            add_blanks(1'b1);
            add_token();
            add_blanks(1'b0);
            msg.push_back(CHAR_COLON);
            add_blanks(1'b1);
            add_token();
            add_blanks(1'b0);
            // last value may end on the final byte without a newline
            if (p != npairs - 1 || $urandom_range(0, 2) != 0)
                msg.push_back(CHAR_NEWLINE);
        end
        if (kind <= 2)
        begin
            idx = $urandom_range(0, msg.size() - 1);
            case ($urandom_range(0, 3))
                0: msg[idx] = 8'($urandom_range(0, 255));
                1: msg.insert(idx, CHAR_COLON);
                2: msg.insert(idx, CHAR_NEWLINE);
                default: msg = msg[0:idx];
            endcase
        end
    endtask

    // Result side: random stall bursts while idling is enabled.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.token_done   = m_axis_tdata[0];
            got.token_is_key = m_axis_tuser;
            got.token_start  = m_axis_tdata[16:1];
            got.token_length = m_axis_tdata[32:17];
            got.line_number  = m_axis_tdata[48:33];
            got.pair_count   = m_axis_tdata[56:49];
            got.parse_error  = m_axis_tdata[57];
            got.message_done = m_axis_tlast;
            got.message_ok   = m_axis_tdata[58];
            sb.check_result(got);
        end
    end

    // Watchdog: cycles without any transaction on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, sb.pending());
            $display("tb_key_value_text_parser: done, errors");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        idle_on = 1'b1;
        quiet_cycles = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: token at last byte, trimming, each error kind, blank lines, byte extremes
        send_text("a:b");
        send_text(" K :\tv \r\n");
        send_text(":");
        send_text("k:v:");
        send_text("k\n");
        send_text("\n \n");
        msg = '{8'h00, 8'hFF, CHAR_COLON, 8'hFF};
        send_message();

        // hold off until the block has drained
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);

        while (sb.n_bytes < RANDOM_ITEMS - CALM_ITEMS)
        begin
            build_random_message();
            send_message();
        end
        idle_on = 1'b0;
        while (sb.n_bytes < RANDOM_ITEMS)
        begin
            build_random_message();
            send_message();
        end

        // one long message: the pair counter saturates
        repeat (PAIR_RUN)
        begin
            send_byte("k", 1'b0);
            send_byte(CHAR_COLON, 1'b0);
            send_byte("v", 1'b0);
            send_byte(CHAR_NEWLINE, 1'b0);
        end
        send_byte("k", 1'b0);
        send_byte(CHAR_COLON, 1'b0);
        send_byte("x", 1'b1);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d messages / %0d bytes: %0d accepted, %0d with errors, %0d tokens",
                 sb.n_msgs, sb.n_bytes, sb.n_ok_msgs, sb.n_err_msgs, sb.n_tokens);
        $display("%0d results checked, %0d mismatches; last message saturated the pair counter",
                 sb.n_checked, sb.n_fail);
        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("tb_key_value_text_parser: done, clean");
        else
            $display("tb_key_value_text_parser: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kvtp_pkg.sv
sv/key_value_text_parser.sv
sim/tb_key_value_text_parser.sv
